[rtl/core/dvi_ci_pkg.sv]
// Shared types, codes and the operand table of the DVI command interpreter.
// No dependencies; used by dvi_command_interpreter_core.
package dvi_ci_pkg;

  localparam int STACK_LEVELS = 128;
  localparam int LVL_W = $clog2(STACK_LEVELS + 1);
  localparam int IDX_W = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;
  localparam int ROW_W = 6 * 32;

  localparam logic [4:0] PH_OPCODE = 5'd0;
  localparam logic [4:0] PH_SKIP = 5'd31;

  localparam logic [3:0] EV_SETCHAR = 4'd0;
  localparam logic [3:0] EV_PUTCHAR = 4'd1;
  localparam logic [3:0] EV_SETRULE = 4'd2;
  localparam logic [3:0] EV_PUTRULE = 4'd3;
  localparam logic [3:0] EV_FONTSEL = 4'd4;
  localparam logic [3:0] EV_FONTDEF = 4'd5;
  localparam logic [3:0] EV_BOP = 4'd6;
  localparam logic [3:0] EV_EOP = 4'd7;
  localparam logic [3:0] EV_PRE = 4'd8;
  localparam logic [3:0] EV_POST = 4'd9;
  localparam logic [3:0] EV_DONE = 4'd10;
  localparam logic [3:0] EV_ERROR = 4'd11;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_VERSION = 3'd1;
  localparam logic [2:0] ERR_OPCODE = 3'd2;
  localparam logic [2:0] ERR_TRAILER = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd5;

  localparam logic [7:0] OP_SET_RULE = 8'd132;
  localparam logic [7:0] OP_PUT_RULE = 8'd137;
  localparam logic [7:0] OP_NOP = 8'd138;
  localparam logic [7:0] OP_BOP = 8'd139;
  localparam logic [7:0] OP_EOP = 8'd140;
  localparam logic [7:0] OP_PUSH = 8'd141;
  localparam logic [7:0] OP_POP = 8'd142;
  localparam logic [7:0] OP_W0 = 8'd147;
  localparam logic [7:0] OP_X0 = 8'd152;
  localparam logic [7:0] OP_Y0 = 8'd161;
  localparam logic [7:0] OP_Z0 = 8'd166;
  localparam logic [7:0] OP_FNT_NUM_0 = 8'd171;
  localparam logic [7:0] OP_XXX4 = 8'd242;
  localparam logic [7:0] OP_PRE = 8'd247;
  localparam logic [7:0] OP_POST = 8'd248;
  localparam logic [7:0] OP_TRAILER = 8'd249;
  localparam logic [7:0] DVI_ID = 8'd2;
  localparam logic [7:0] TRAILER_BYTE = 8'd223;

  typedef struct packed {
    logic [2:0] len;
    logic       sgn;
  } opnd_t;

  function automatic opnd_t opnd_spec(input logic [7:0] op, input logic [3:0] idx);
    opnd_t s;
    s = '{len: 3'd0, sgn: 1'b0};
    if (op >= 8'd128 && op <= 8'd131) begin
      if (idx == 4'd0) s = '{len: 3'(op - 8'd127), sgn: (op == 8'd131)};
    end else if (op == OP_SET_RULE || op == OP_PUT_RULE) begin
      if (idx < 4'd2) s = '{len: 3'd4, sgn: 1'b1};
    end else if (op >= 8'd133 && op <= 8'd136) begin
      if (idx == 4'd0) s = '{len: 3'(op - 8'd132), sgn: (op == 8'd136)};
    end else if (op == OP_BOP) begin
      if (idx < 4'd11) s = '{len: 3'd4, sgn: 1'b1};
    end else if (idx == 4'd0 && op >= 8'd143 && op <= 8'd146) begin
      s = '{len: 3'(op - 8'd142), sgn: 1'b1};
    end else if (idx == 4'd0 && op >= 8'd148 && op <= 8'd151) begin
      s = '{len: 3'(op - 8'd147), sgn: 1'b1};
    end else if (idx == 4'd0 && op >= 8'd153 && op <= 8'd156) begin
      s = '{len: 3'(op - 8'd152), sgn: 1'b1};
    end else if (idx == 4'd0 && op >= 8'd157 && op <= 8'd160) begin
      s = '{len: 3'(op - 8'd156), sgn: 1'b1};
    end else if (idx == 4'd0 && op >= 8'd162 && op <= 8'd164) begin
      s = '{len: 3'(op - 8'd161), sgn: 1'b1};
    end else if (idx == 4'd0 && op == 8'd165) begin
      s = '{len: 3'd4, sgn: 1'b1};
    end else if (idx == 4'd0 && op >= 8'd167 && op <= 8'd170) begin
      s = '{len: 3'(op - 8'd166), sgn: 1'b1};
    end else if (idx == 4'd0 && op >= 8'd235 && op <= 8'd238) begin
      s = '{len: 3'(op - 8'd234), sgn: (op == 8'd238)};
    end else if (idx == 4'd0 && op >= 8'd239 && op <= OP_XXX4) begin
      s = '{len: 3'(op - 8'd238), sgn: (op == OP_XXX4)};
    end else if (op >= 8'd243 && op <= 8'd246) begin
      if (idx == 4'd0) s = '{len: 3'(op - 8'd242), sgn: (op == 8'd246)};
      else if (idx <= 4'd3) s = '{len: 3'd4, sgn: 1'b1};
      else if (idx <= 4'd5) s = '{len: 3'd1, sgn: 1'b0};
    end else if (op == OP_PRE) begin
      if (idx == 4'd0 || idx == 4'd4) s = '{len: 3'd1, sgn: 1'b0};
      else if (idx <= 4'd3) s = '{len: 3'd4, sgn: 1'b1};
    end else if (op == OP_POST) begin
      if (idx <= 4'd5) s = '{len: 3'd4, sgn: 1'b1};
      else if (idx <= 4'd7) s = '{len: 3'd2, sgn: 1'b0};
    end else if (op == OP_TRAILER) begin
      if (idx == 4'd0) s = '{len: 3'd4, sgn: 1'b1};
      else if (idx <= 4'd2) s = '{len: 3'd1, sgn: 1'b0};
    end
    return s;
  endfunction

endpackage

[rtl/core/dvi_command_interpreter_core.sv]
// DVI command interpreter: byte-serial opcode decoder, position registers
// and a push/pop stack held in one synchronous memory. Depends on dvi_ci_pkg.
//
// Usage: raw DVI bytes enter on the s_ channel, one per request. Each
// request updates the parser, the position registers or the stack, and
// may produce one event on the m_ channel: characters, rules, font
// selections and definitions, page marks, preamble, postamble, trailer end
// and errors. Operands are gathered big-endian over the following bytes.
// Throughput is one byte per cycle, including push and pop, unless the
// output stalls: the stack is one memory row of h, v, w, x, y and z per
// level, written by push, and a pop's row, read into a registered output,
// is forwarded into the register file in the cycle after the pop.
// An event appears on the m_ channel in the cycle after the byte that caused
// it. The single output register holds it while the receiver stalls; a
// new byte is taken in the same cycle the held event leaves, so only a
// stall that keeps the register full stops the input.
// Reset clears the parser and registers; stack rows are never cleared and
// only rows written by a push are read. After the trailer end or an error
// the block takes and drops every byte until reset.
module dvi_command_interpreter_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // stream_byte[7:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [199:0] m_tdata    // event_kind[3:0], h_pos, v_pos, code_or_number,
                                  // arg_a, arg_b, arg_c (32 each), error_code[2:0], pad
);
  import dvi_ci_pkg::*;

  logic [31:0] h, v, w, x, y, z;
  logic [LVL_W-1:0] level;
  logic [4:0] phase;
  logic [7:0] cur_op;
  logic [31:0] accum;
  logic [2:0] bytes_left;
  logic [31:0] skip_count;
  logic [31:0] held [4];
  logic halted;
  logic pop_pending;

  logic [ROW_W-1:0] stack_mem [STACK_LEVELS];
  logic [ROW_W-1:0] rdata;

  logic [31:0] eh, ev, ew, ex, ey, ez;
  logic [31:0] h_next, v_next, w_next, x_next, y_next, z_next;
  logic [LVL_W-1:0] level_next;
  logic [4:0] phase_next;
  logic [7:0] cur_op_next;
  logic [31:0] accum_next;
  logic [2:0] bytes_left_next;
  logic [31:0] skip_next;
  logic [31:0] held_next [4];
  logic halted_next;
  logic push_we, pop_re;
  logic [IDX_W-1:0] waddr, raddr;

  logic evt;
  logic [3:0] e_kind;
  logic [31:0] e_code, e_a, e_b, e_c;
  logic [2:0] e_err;

  logic accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept = s_tvalid && s_tready;

  assign eh = pop_pending ? rdata[31:0] : h;
  assign ev = pop_pending ? rdata[63:32] : v;
  assign ew = pop_pending ? rdata[95:64] : w;
  assign ex = pop_pending ? rdata[127:96] : x;
  assign ey = pop_pending ? rdata[159:128] : y;
  assign ez = pop_pending ? rdata[191:160] : z;

  always_comb begin
    logic [7:0] b;
    logic [3:0] idx;
    opnd_t spec, nspec, ospec;
    logic [31:0] acc, val;
    logic [2:0] bl;
    logic to_skip;
    logic done_op;
    b = s_tdata;
    idx = 4'(phase - 5'd1);
    spec = opnd_spec(cur_op, idx);
    nspec = opnd_spec(cur_op, 4'(idx + 4'd1));
    ospec = opnd_spec(b, 4'd0);
    acc = {accum[23:0], b};
    bl = bytes_left - 3'd1;
    to_skip = 1'b0;
    done_op = 1'b0;
    case (spec.len)
      3'd1: val = {{24{spec.sgn & acc[7]}}, acc[7:0]};
      3'd2: val = {{16{spec.sgn & acc[15]}}, acc[15:0]};
      3'd3: val = {{8{spec.sgn & acc[23]}}, acc[23:0]};
      default: val = acc;
    endcase

    h_next = eh; v_next = ev; w_next = ew; x_next = ex; y_next = ey; z_next = ez;
    level_next = level;
    phase_next = phase;
    cur_op_next = cur_op;
    accum_next = accum;
    bytes_left_next = bytes_left;
    skip_next = skip_count;
    for (int i = 0; i < 4; i++) held_next[i] = held[i];
    halted_next = halted;
    push_we = 1'b0;
    pop_re = 1'b0;
    waddr = level[IDX_W-1:0];
    raddr = IDX_W'(level - LVL_W'(1));
    evt = 1'b0;
    e_kind = EV_SETCHAR;
    e_code = '0; e_a = '0; e_b = '0; e_c = '0;
    e_err = ERR_NONE;

    if (accept && !halted) begin
      if (phase == PH_OPCODE) begin
        if (b <= 8'd127) begin
          evt = 1'b1; e_kind = EV_SETCHAR; e_code = 32'(b);
        end else if (b >= OP_FNT_NUM_0 && b <= 8'd234) begin
          evt = 1'b1; e_kind = EV_FONTSEL; e_code = 32'(b - OP_FNT_NUM_0);
        end else if (b >= 8'd250) begin
          evt = 1'b1; e_kind = EV_ERROR; e_err = ERR_OPCODE; e_code = 32'(b);
          halted_next = 1'b1;
        end else begin
          case (b)
            OP_NOP: ;
            OP_EOP: begin
              evt = 1'b1; e_kind = EV_EOP;
            end
            OP_PUSH: begin
              if (level >= LVL_W'(STACK_LEVELS)) begin
                evt = 1'b1; e_kind = EV_ERROR; e_err = ERR_OVERFLOW; halted_next = 1'b1;
              end else begin
                push_we = 1'b1;
                level_next = level + LVL_W'(1);
              end
            end
            OP_POP: begin
              if (level == '0) begin
                evt = 1'b1; e_kind = EV_ERROR; e_err = ERR_UNDERFLOW; halted_next = 1'b1;
              end else begin
                pop_re = 1'b1;
                level_next = level - LVL_W'(1);
              end
            end
            OP_W0: h_next = eh + ew;
            OP_X0: h_next = eh + ex;
            OP_Y0: v_next = ev + ey;
            OP_Z0: v_next = ev + ez;
            default: begin
              if (b == OP_BOP) begin
                h_next = '0; v_next = '0; w_next = '0;
                x_next = '0; y_next = '0; z_next = '0;
                level_next = '0;
              end
              if (ospec.len != 3'd0) begin
                cur_op_next = b;
                phase_next = 5'd1;
                bytes_left_next = ospec.len;
                accum_next = '0;
              end
            end
          endcase
        end
      end else if (phase == PH_SKIP) begin
        skip_next = (skip_count != '0) ? skip_count - 32'd1 : skip_count;
        if (skip_next == '0) done_op = 1'b1;
      end else if (spec.len == 3'd0 || bytes_left == 3'd0) begin
        phase_next = PH_OPCODE;
      end else begin
        accum_next = acc;
        bytes_left_next = bl;
        if (bl == 3'd0) begin
          phase_next = PH_OPCODE;
          if (nspec.len != 3'd0) begin
            phase_next = 5'(idx) + 5'd2;
            bytes_left_next = nspec.len;
            accum_next = '0;
          end
          if (cur_op >= 8'd128 && cur_op <= 8'd131) begin
            evt = 1'b1; e_kind = EV_SETCHAR; e_code = val;
          end else if (cur_op >= 8'd133 && cur_op <= 8'd136) begin
            evt = 1'b1; e_kind = EV_PUTCHAR; e_code = val;
          end else if (cur_op == OP_SET_RULE || cur_op == OP_PUT_RULE) begin
            if (idx == 4'd0) held_next[0] = val;
            else begin
              if (held[0] != '0 && !held[0][31] && val != '0 && !val[31]) begin
                evt = 1'b1;
                e_kind = (cur_op == OP_SET_RULE) ? EV_SETRULE : EV_PUTRULE;
                e_a = held[0]; e_b = val;
              end
              if (cur_op == OP_SET_RULE) h_next = eh + val;
            end
          end else if (cur_op == OP_BOP) begin
            if (idx == 4'd0) held_next[0] = val;
            if (idx == 4'd10) begin
              evt = 1'b1; e_kind = EV_BOP; e_code = held[0];
            end
          end else if (cur_op >= 8'd143 && cur_op <= 8'd146) begin
            h_next = eh + val;
          end else if (cur_op >= 8'd148 && cur_op <= 8'd151) begin
            w_next = val; h_next = eh + val;
          end else if (cur_op >= 8'd153 && cur_op <= 8'd156) begin
            x_next = val; h_next = eh + val;
          end else if (cur_op >= 8'd157 && cur_op <= 8'd160) begin
            v_next = ev + val;
          end else if (cur_op >= 8'd162 && cur_op <= 8'd165) begin
            y_next = val; v_next = ev + val;
          end else if (cur_op >= 8'd167 && cur_op <= 8'd170) begin
            z_next = val; v_next = ev + val;
          end else if (cur_op >= 8'd235 && cur_op <= 8'd238) begin
            evt = 1'b1; e_kind = EV_FONTSEL; e_code = val;
          end else if (cur_op >= 8'd239 && cur_op <= OP_XXX4) begin
            skip_next = (cur_op == OP_XXX4 && val[31]) ? '0 : val;
            to_skip = 1'b1;
          end else if (cur_op >= 8'd243 && cur_op <= 8'd246) begin
            if (idx <= 4'd3) held_next[idx[1:0]] = val;
            else if (idx == 4'd4) skip_next = val;
            else begin
              skip_next = skip_count + val; to_skip = 1'b1;
            end
          end else if (cur_op == OP_PRE) begin
            if (idx == 4'd0) begin
              if (val != 32'(DVI_ID)) begin
                evt = 1'b1; e_kind = EV_ERROR; e_err = ERR_VERSION; e_code = val;
                halted_next = 1'b1; phase_next = PH_OPCODE;
              end
            end else if (idx <= 4'd3) held_next[idx[1:0]] = val;
            else begin
              skip_next = val; to_skip = 1'b1;
            end
          end else if (cur_op == OP_POST) begin
            if (idx == 4'd7) begin
              evt = 1'b1; e_kind = EV_POST; e_code = val;
            end
          end else if (cur_op == OP_TRAILER) begin
            if (idx == 4'd2) begin
              evt = 1'b1;
              halted_next = 1'b1;
              phase_next = PH_OPCODE;
              if (val != 32'(TRAILER_BYTE)) begin
                e_kind = EV_ERROR; e_err = ERR_TRAILER;
              end else begin
                e_kind = EV_DONE;
              end
            end
          end
          if (to_skip) begin
            if (skip_next == '0) done_op = 1'b1;
            else phase_next = PH_SKIP;
          end
        end
      end
      if (done_op) begin
        phase_next = PH_OPCODE;
        if (cur_op >= 8'd243 && cur_op <= 8'd246) begin
          evt = 1'b1; e_kind = EV_FONTDEF;
          e_code = held_next[0]; e_a = held_next[1]; e_b = held_next[2]; e_c = held_next[3];
        end else if (cur_op == OP_PRE) begin
          evt = 1'b1; e_kind = EV_PRE;
          e_a = held_next[1]; e_b = held_next[2]; e_c = held_next[3];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_we) stack_mem[waddr] <= {ez, ey, ex, ew, ev, eh};
    if (pop_re) rdata <= stack_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h <= '0; v <= '0; w <= '0; x <= '0; y <= '0; z <= '0;
      level <= '0;
      phase <= PH_OPCODE;
      cur_op <= '0;
      accum <= '0;
      bytes_left <= '0;
      skip_count <= '0;
      for (int i = 0; i < 4; i++) held[i] <= '0;
      halted <= 1'b0;
      pop_pending <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      h <= h_next; v <= v_next; w <= w_next;
      x <= x_next; y <= y_next; z <= z_next;
      level <= level_next;
      phase <= phase_next;
      cur_op <= cur_op_next;
      accum <= accum_next;
      bytes_left <= bytes_left_next;
      skip_count <= skip_next;
      for (int i = 0; i < 4; i++) held[i] <= held_next[i];
      halted <= halted_next;
      pop_pending <= pop_re;
      if (evt) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt) m_tdata <= {1'b0, e_err, e_c, e_b, e_a, e_code, ev, eh, e_kind};
  end

  assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halted state was left without reset");
  assert property (@(posedge clk) disable iff (rst) level <= LVL_W'(STACK_LEVELS))
    else $error("stack level beyond stack depth");
  assert property (@(posedge clk) disable iff (rst) halted |-> !evt && !push_we && !pop_re)
    else $error("activity after halt");
  assert property (@(posedge clk) disable iff (rst)
      evt && e_kind == EV_ERROR |-> e_err != ERR_NONE)
    else $error("error event without error code");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for dvi_command_interpreter_core: drives DVI byte
// streams, predicts every event with its own interpreter model and compares.
// Depends on dvi_ci_pkg and dvi_command_interpreter_core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dvi_ci_pkg::*;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] h_pos;
    logic [31:0] v_pos;
    logic [31:0] code;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [2:0]  err;
  } dvi_event_t;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [199:0] m_tdata;

  dvi_command_interpreter_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  // Byte queue; a negative entry asks the driver to wait for all events.
  int pending_bytes[$];
  dvi_event_t expected_events[$];
  int errors = 0;
  int cycle = 0;
  bit stim_done = 0;

  // Interpreter model state.
  logic [31:0] mh, mv, mw, mx, my, mz;
  logic [31:0] saved_rows[6*STACK_LEVELS];
  int unsigned depth;
  int unsigned phase;
  logic [7:0]  cur_op;
  logic [31:0] accum;
  int unsigned left;
  logic [31:0] skip_left;
  logic [31:0] held[4];
  bit stopped;

  function automatic int unsigned spec_of(logic [7:0] op, int unsigned idx);
    int unsigned o;
    o = op;
    if (o >= 128 && o <= 131) return idx == 0 ? ((o - 127) | (o == 131 ? 8 : 0)) : 0;
    if (o == 132 || o == 137) return idx < 2 ? 12 : 0;
    if (o >= 133 && o <= 136) return idx == 0 ? ((o - 132) | (o == 136 ? 8 : 0)) : 0;
    if (o == 139) return idx < 11 ? 12 : 0;
    if (idx == 0) begin
      if (o >= 143 && o <= 146) return (o - 142) | 8;
      if (o >= 148 && o <= 151) return (o - 147) | 8;
      if (o >= 153 && o <= 156) return (o - 152) | 8;
      if (o >= 157 && o <= 160) return (o - 156) | 8;
      if (o >= 162 && o <= 164) return (o - 161) | 8;
      if (o == 165) return 12;
      if (o >= 167 && o <= 170) return (o - 166) | 8;
      if (o >= 235 && o <= 238) return (o - 234) | (o == 238 ? 8 : 0);
      if (o >= 239 && o <= 242) return (o - 238) | (o == 242 ? 8 : 0);
    end
    if (o >= 243 && o <= 246) begin
      if (idx == 0) return (o - 242) | (o == 246 ? 8 : 0);
      if (idx <= 3) return 12;
      return idx <= 5 ? 1 : 0;
    end
    if (o == OP_PRE) begin
      if (idx == 0 || idx == 4) return 1;
      return idx <= 3 ? 12 : 0;
    end
    if (o == OP_POST) begin
      if (idx <= 5) return 12;
      return idx <= 7 ? 2 : 0;
    end
    if (o == OP_TRAILER) begin
      if (idx == 0) return 12;
      return idx <= 2 ? 1 : 0;
    end
    return 0;
  endfunction

  task automatic push_event(logic [3:0] k, logic [31:0] code, logic [31:0] a,
                            logic [31:0] b, logic [31:0] c, logic [2:0] e);
    dvi_event_t item;
    item = '{kind: k, h_pos: mh, v_pos: mv, code: code, a: a, b: b, c: c, err: e};
    expected_events.push_back(item);
  endtask

  task automatic halt_with(logic [2:0] e, logic [31:0] code);
    stopped = 1;
    phase = PH_OPCODE;
    push_event(EV_ERROR, code, 0, 0, 0, e);
  endtask

  task automatic begin_operand(logic [7:0] op, int unsigned idx);
    cur_op = op;
    phase = idx + 1;
    left = spec_of(op, idx) & 7;
    accum = 0;
  endtask

  task automatic close_skip();
    int unsigned o;
    o = cur_op;
    phase = PH_OPCODE;
    if (o >= 243 && o <= 246) push_event(EV_FONTDEF, held[0], held[1], held[2], held[3], ERR_NONE);
    else if (o == OP_PRE) push_event(EV_PRE, 0, held[1], held[2], held[3], ERR_NONE);
  endtask

  task automatic operand_done(logic [31:0] val, int unsigned idx);
    int unsigned o;
    bit to_skip;
    o = cur_op;
    to_skip = 0;
    if (o >= 128 && o <= 131) push_event(EV_SETCHAR, val, 0, 0, 0, ERR_NONE);
    else if (o >= 133 && o <= 136) push_event(EV_PUTCHAR, val, 0, 0, 0, ERR_NONE);
    else if (o == 132 || o == 137) begin
      if (idx == 0) held[0] = val;
      else begin
        if (held[0] != 0 && !held[0][31] && val != 0 && !val[31])
          push_event(o == 132 ? EV_SETRULE : EV_PUTRULE, 0, held[0], val, 0, ERR_NONE);
        if (o == 132) mh += val;
      end
    end else if (o == 139) begin
      if (idx == 0) held[0] = val;
      if (idx == 10) push_event(EV_BOP, held[0], 0, 0, 0, ERR_NONE);
    end else if (o >= 143 && o <= 146) mh += val;
    else if (o >= 148 && o <= 151) begin mw = val; mh += val; end
    else if (o >= 153 && o <= 156) begin mx = val; mh += val; end
    else if (o >= 157 && o <= 160) mv += val;
    else if (o >= 162 && o <= 165) begin my = val; mv += val; end
    else if (o >= 167 && o <= 170) begin mz = val; mv += val; end
    else if (o >= 235 && o <= 238) push_event(EV_FONTSEL, val, 0, 0, 0, ERR_NONE);
    else if (o >= 239 && o <= 242) begin
      skip_left = (o == 242 && val[31]) ? 0 : val;
      to_skip = 1;
    end else if (o >= 243 && o <= 246) begin
      if (idx <= 3) held[idx] = val;
      else if (idx == 4) skip_left = val;
      else begin skip_left += val; to_skip = 1; end
    end else if (o == OP_PRE) begin
      if (idx == 0) begin
        if (val != DVI_ID) begin halt_with(ERR_VERSION, val); return; end
      end else if (idx <= 3) held[idx] = val;
      else begin skip_left = val; to_skip = 1; end
    end else if (o == OP_POST) begin
      if (idx == 7) push_event(EV_POST, val, 0, 0, 0, ERR_NONE);
    end else if (o == OP_TRAILER) begin
      if (idx == 2) begin
        if (val != TRAILER_BYTE) begin halt_with(ERR_TRAILER, 0); return; end
        stopped = 1;
        phase = PH_OPCODE;
        push_event(EV_DONE, 0, 0, 0, 0, ERR_NONE);
        return;
      end
    end
    if (to_skip) begin
      if (skip_left == 0) close_skip();
      else phase = PH_SKIP;
      return;
    end
    if (spec_of(cur_op, idx + 1) != 0) begin_operand(cur_op, idx + 1);
    else phase = PH_OPCODE;
  endtask

  task automatic decode_opcode(logic [7:0] op);
    int unsigned base;
    if (op <= 127) begin push_event(EV_SETCHAR, op, 0, 0, 0, ERR_NONE); return; end
    if (op >= OP_FNT_NUM_0 && op <= 234) begin
      push_event(EV_FONTSEL, op - OP_FNT_NUM_0, 0, 0, 0, ERR_NONE);
      return;
    end
    if (op >= 250) begin halt_with(ERR_OPCODE, op); return; end
    case (op)
      OP_NOP: return;
      OP_EOP: begin push_event(EV_EOP, 0, 0, 0, 0, ERR_NONE); return; end
      OP_PUSH: begin
        if (depth >= STACK_LEVELS) begin halt_with(ERR_OVERFLOW, 0); return; end
        base = depth * 6;
        saved_rows[base] = mh; saved_rows[base+1] = mv; saved_rows[base+2] = mw;
        saved_rows[base+3] = mx; saved_rows[base+4] = my; saved_rows[base+5] = mz;
        depth++;
        return;
      end
      OP_POP: begin
        if (depth == 0) begin halt_with(ERR_UNDERFLOW, 0); return; end
        depth--;
        base = depth * 6;
        mh = saved_rows[base]; mv = saved_rows[base+1]; mw = saved_rows[base+2];
        mx = saved_rows[base+3]; my = saved_rows[base+4]; mz = saved_rows[base+5];
        return;
      end
      OP_W0: begin mh += mw; return; end
      OP_X0: begin mh += mx; return; end
      OP_Y0: begin mv += my; return; end
      OP_Z0: begin mv += mz; return; end
      OP_BOP: begin
        mh = 0; mv = 0; mw = 0; mx = 0; my = 0; mz = 0;
        depth = 0;
      end
      default: ;
    endcase
    if (spec_of(op, 0) != 0) begin_operand(op, 0);
  endtask

  task automatic interpret_byte(logic [7:0] b);
    int unsigned idx, spec, len;
    logic [31:0] val;
    if (stopped) return;
    if (phase == PH_OPCODE) begin decode_opcode(b); return; end
    if (phase == PH_SKIP) begin
      if (skip_left > 0) skip_left--;
      if (skip_left == 0) close_skip();
      return;
    end
    idx = phase - 1;
    spec = spec_of(cur_op, idx);
    len = spec & 7;
    if (len == 0 || left == 0) begin phase = PH_OPCODE; return; end
    accum = {accum[23:0], b};
    left--;
    if (left != 0) return;
    val = accum;
    if ((spec & 8) && len < 4 && val[8*len-1]) val |= 32'hFFFF_FFFF << (8 * len);
    operand_done(val, idx);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
  endtask

  // Driver.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        interpret_byte(s_tdata);
        send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0 && pending_bytes[0] < 0) begin
          s_tvalid <= 1'b0;
          if (expected_events.size() == 0) void'(pending_bytes.pop_front());
        end else if (pending_bytes.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= 8'(pending_bytes.pop_front());
        end else begin
          s_tvalid <= 1'b0;
          if (stim_done == 0) stim_done <= 1'b1;
        end
      end
    end
  end

  // Monitor.
  int recv_gap = 0;
  always @(posedge clk) begin
    dvi_event_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[3:0], m_tdata[35:4], m_tdata[67:36], m_tdata[99:68],
               m_tdata[131:100], m_tdata[163:132], m_tdata[195:164], m_tdata[198:196]};
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected event_kind", 32'(got.kind), '0);
        end else begin
          want = expected_events.pop_front();
          if (got.kind !== want.kind)
            report_mismatch("event_kind", 32'(got.kind), 32'(want.kind));
          if (got.h_pos !== want.h_pos) report_mismatch("h_pos", got.h_pos, want.h_pos);
          if (got.v_pos !== want.v_pos) report_mismatch("v_pos", got.v_pos, want.v_pos);
          if (got.code !== want.code) report_mismatch("code_or_number", got.code, want.code);
          if (got.a !== want.a) report_mismatch("arg_a", got.a, want.a);
          if (got.b !== want.b) report_mismatch("arg_b", got.b, want.b);
          if (got.c !== want.c) report_mismatch("arg_c", got.c, want.c);
          if (got.err !== want.err)
            report_mismatch("error_code", 32'(got.err), 32'(want.err));
        end
        recv_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic add_byte(logic [7:0] v);
    pending_bytes.push_back(int'(v));
  endtask

  task automatic add_bytes(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
  endtask

  task automatic add_preamble();
    int k;
    add_byte(OP_PRE);
    add_byte(DVI_ID);
    add_bytes($urandom, 4); add_bytes($urandom, 4); add_bytes($urandom, 4);
    k = $urandom_range(0, 3);
    add_byte(8'(k));
    for (int i = 0; i < k; i++) add_byte(8'($urandom_range(0, 255)));
  endtask

  // One random command that never halts the interpreter.
  task automatic add_command(inout int level);
    int pick, n, m;
    logic [7:0] op;
    pick = $urandom_range(0, 19);
    case (pick)
      0, 1: add_byte(8'($urandom_range(0, 127)));
      2: begin
        op = 8'($urandom_range(128, 131)); add_byte(op); add_bytes($urandom, int'(op) - 127);
      end
      3: begin
        op = 8'($urandom_range(133, 136)); add_byte(op); add_bytes($urandom, int'(op) - 132);
      end
      4: begin
        add_byte($urandom_range(0, 1) ? OP_SET_RULE : OP_PUT_RULE);
        add_bytes($urandom_range(0, 1) ? $urandom_range(1, 1000) : $urandom, 4);
        add_bytes($urandom_range(0, 1) ? $urandom_range(1, 1000) : $urandom, 4);
      end
      5: if (level < STACK_LEVELS) begin add_byte(OP_PUSH); level++; end
      6: if (level > 0) begin add_byte(OP_POP); level--; end
      7: begin
        op = 8'($urandom_range(143, 170));
        add_byte(op);
        if (spec_of(op, 0) != 0) add_bytes($urandom, int'(spec_of(op, 0) & 7));
      end
      8: add_byte(8'($urandom_range(OP_FNT_NUM_0, 234)));
      9: begin
        op = 8'($urandom_range(235, 238)); add_byte(op); add_bytes($urandom, int'(op) - 234);
      end
      10: begin
        op = 8'($urandom_range(239, 242));
        add_byte(op);
        n = $urandom_range(0, 3);
        if (op == OP_XXX4 && $urandom_range(0, 3) == 0) begin
          add_bytes(-32'($urandom_range(1, 9)), 4);
          n = 0;
        end else begin
          add_bytes(32'(n), int'(op) - 238);
        end
        for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
      end
      11: begin
        op = 8'($urandom_range(243, 246));
        add_byte(op);
        add_bytes($urandom, int'(op) - 242);
        for (int i = 0; i < 3; i++) add_bytes($urandom, 4);
        n = $urandom_range(0, 2);
        m = ($urandom_range(0, 3) == 0) ? 0 : 1;
        add_byte(8'(n));
        add_byte(8'(m));
        for (int i = 0; i < n + m; i++) add_byte(8'($urandom_range(0, 255)));
      end
      12: add_byte(OP_NOP);
      13: add_byte($urandom_range(0, 1) ? OP_W0 : OP_X0);
      14: add_byte($urandom_range(0, 1) ? OP_Y0 : OP_Z0);
      default: add_byte(8'($urandom_range(0, 127)));
    endcase
  endtask

  task automatic add_page();
    int level, n;
    level = 0;
    add_byte(OP_BOP);
    for (int i = 0; i < 11; i++) add_bytes($urandom, 4);
    n = $urandom_range(3, 20);
    for (int i = 0; i < n; i++) add_command(level);
    add_byte(OP_EOP);
  endtask

  task automatic add_trailer(bit good);
    add_byte(OP_POST);
    for (int i = 0; i < 6; i++) add_bytes($urandom, 4);
    add_bytes($urandom, 2); add_bytes($urandom, 2);
    add_byte(OP_TRAILER);
    add_bytes($urandom, 4);
    add_byte(DVI_ID);
    add_byte(good ? TRAILER_BYTE : 8'($urandom_range(0, 222)));
  endtask

  initial begin
    mh = 0; mv = 0; mw = 0; mx = 0; my = 0; mz = 0;
    depth = 0; phase = PH_OPCODE; cur_op = 0; accum = 0; left = 0;
    skip_left = 0; held = '{default: 0}; stopped = 0;
    // Directed: preamble, extremes of chars, set4, rules and xxx4 length, 3-byte v-move, push/pop.
    add_preamble();
    add_byte(OP_BOP);
    for (int i = 0; i < 11; i++) add_bytes(32'h8000_0000, 4);
    add_byte(8'd0); add_byte(8'd127);
    add_byte(8'd131); add_bytes(32'hFFFF_FFFF, 4);
    add_byte(8'd164); add_bytes(32'h80_0000, 3);
    add_byte(8'd164); add_bytes(32'h7F_FFFF, 3);
    add_byte(OP_SET_RULE); add_bytes(5, 4); add_bytes(0, 4);
    add_byte(OP_PUT_RULE); add_bytes(32'h7FFF_FFFF, 4); add_bytes(1, 4);
    add_byte(OP_PUSH); add_byte(OP_POP);
    add_byte(OP_PUSH); add_byte(8'd143); add_byte(8'd9); add_byte(OP_POP);
    add_byte(OP_XXX4); add_bytes(32'hFFFF_FFFF, 4);
    add_byte(OP_EOP);
    pending_bytes.push_back(-1);
    while (pending_bytes.size() < 940) add_page();
    add_trailer($urandom_range(0, 1) == 1);
    // The block has halted; these bytes must be dropped silently.
    add_byte(8'd255); add_byte(8'd0); add_byte(OP_PUSH);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done);
    wait (expected_events.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_events.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle++;
    if (cycle > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end
endmodule
